[src/keyed_record_table_core_defines.svh]
// Assertion macros used by the table core back end (krt_back).
// Each macro expects clk and rst_n in the enclosing module.
`ifndef KEYED_RECORD_TABLE_CORE_DEFINES_SVH
`define KEYED_RECORD_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KRT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("krt assertion failed");

// next-cycle implication
`define KRT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("krt assertion failed");

`else

`define KRT_ASSERT_IMP(name, ante, cons)
`define KRT_ASSERT_NXT(name, ante, cons)

`endif

`endif

[src/krt_pkg.sv]
`default_nettype none

package krt_pkg;

  // field widths, fixed by the record format
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 40;
  localparam int NAMEW_W  = 64;
  localparam int NAMEL_W  = 24;
  localparam int SECRET_W = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int UCNT_W   = 5;

  // default table depth
  localparam int SLOT_COUNT_DEF = 16;

  // front-to-back command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // action codes on the input beat
  localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOK = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_LIST = 2'd3;

  // decoded operation, one-hot
  typedef enum logic [3:0] {
    OP_ADD  = 4'b0001,
    OP_DEL  = 4'b0010,
    OP_LOOK = 4'b0100,
    OP_LIST = 4'b1000
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5,
    ST_LIST      = 3'd6
  } status_t;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [NAMEW_W-1:0]  name_high;
    logic [NAMEW_W-1:0]  name_middle;
    logic [NAMEL_W-1:0]  name_low;
    logic [SECRET_W-1:0] secret;
  } rec_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t  op;
    rec_t rec;
  } cmd_t;

endpackage

`default_nettype wire

[src/krt_if.sv]
`default_nettype none

// request channel
interface krt_in_if;
  import krt_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [NAMEW_W-1:0]  name_high;
  logic [NAMEW_W-1:0]  name_middle;
  logic [NAMEL_W-1:0]  name_low;
  logic [SECRET_W-1:0] secret;

  modport source (
    output valid, action, key, name_high, name_middle, name_low, secret,
    input  ready
  );
  modport sink (
    input  valid, action, key, name_high, name_middle, name_low, secret,
    output ready
  );
endinterface

// result channel
interface krt_out_if;
  import krt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [SLOT_W-1:0]   slot;
  logic [UCNT_W-1:0]   user_count;
  logic [KEY_W-1:0]    out_key;
  logic [NAMEW_W-1:0]  out_name_high;
  logic [NAMEW_W-1:0]  out_name_middle;
  logic [NAMEL_W-1:0]  out_name_low;
  logic [SECRET_W-1:0] out_secret;
  logic                last;

  modport source (
    output valid, status, found, slot, user_count, out_key, out_name_high,
           out_name_middle, out_name_low, out_secret, last,
    input  ready
  );
  modport sink (
    input  valid, status, found, slot, user_count, out_key, out_name_high,
           out_name_middle, out_name_low, out_secret, last,
    output ready
  );
endinterface

`default_nettype wire

[src/krt_front.sv]
`default_nettype none

module krt_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  krt_in_if.sink             in_ch,
  output logic               q_vld,
  output krt_pkg::cmd_t      q_cmd,
  input  wire logic          q_pop
);
  import krt_pkg::*;

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  // classify the incoming beat
  always_comb begin
    cmd_in.rec.key         = in_ch.key;
    cmd_in.rec.name_high   = in_ch.name_high;
    cmd_in.rec.name_middle = in_ch.name_middle;
    cmd_in.rec.name_low    = in_ch.name_low;
    cmd_in.rec.secret      = in_ch.secret;
    unique case (in_ch.action)
      ACT_ADD:  cmd_in.op = OP_ADD;
      ACT_DEL:  cmd_in.op = OP_DEL;
      ACT_LOOK: cmd_in.op = OP_LOOK;
      ACT_LIST: cmd_in.op = OP_LIST;
      default:  cmd_in.op = OP_LIST;
    endcase
  end

  // queue handshake
  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_vld       = (cnt_r != '0);
  assign pop         = q_pop && q_vld;
  assign q_cmd       = q_mem_r[rptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QPTR_W'(1);
      if (pop)  rptr_r <= rptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wptr_r] <= cmd_in;
  end

endmodule

`default_nettype wire

[src/krt_back.sv]
`default_nettype none
`include "keyed_record_table_core_defines.svh"

module krt_back #(
  parameter int SLOT_COUNT = krt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_vld,
  input  wire krt_pkg::cmd_t q_cmd,
  output logic               q_pop,
  krt_out_if.source          out_ch
);
  import krt_pkg::*;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_W = $clog2(SLOT_COUNT + 1);
  localparam int CNT_W  = SCAN_W;
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [SCAN_W-1:0] idx_r;
  logic              p_vld_r;
  logic [IDX_W-1:0]  p_idx_r;
  rec_t              rd_data_r;
  rec_t              slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic [CNT_W-1:0]  count_r;
  logic              hit_r, free_r, listed_r;
  logic [IDX_W-1:0]  hit_idx_r, free_idx_r;
  rec_t              hit_rec_r;

  // output register
  logic              o_vld_r;
  status_t           o_status_r;
  logic              o_found_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [UCNT_W-1:0] o_count_r;
  rec_t              o_rec_r;
  logic              o_last_r;

  logic              out_space, slot_ok, key_eq, is_list;
  logic              list_hold, adv, issue, eval, list_emit, more_valid;
  logic              fin_go, fin_emit;
  status_t           fin_status;
  logic              fin_found;
  logic [IDX_W-1:0]  fin_slot;
  rec_t              fin_rec;
  logic              wr_en, set_valid, clr_valid;
  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  count_nxt;

  // scan pipeline control
  assign out_space = !o_vld_r || out_ch.ready;
  assign slot_ok   = valid_r[p_idx_r];
  assign key_eq    = (rd_data_r.key == cmd_r.rec.key);
  assign is_list   = (cmd_r.op == OP_LIST);
  assign list_hold = (state_r == S_SCAN) && p_vld_r && is_list && slot_ok && !out_space;
  assign adv       = (state_r == S_SCAN) && !list_hold;
  assign issue     = adv && (idx_r != SCAN_END);
  assign eval      = adv && p_vld_r;
  assign list_emit = eval && is_list && slot_ok;
  assign fin_go    = (state_r == S_FIN) && (out_space || (is_list && listed_r));
  assign fin_emit  = fin_go && !(is_list && listed_r);
  assign q_pop     = (state_r == S_IDLE) && q_vld;

  // any valid slot above the one being listed
  always_comb begin
    more_valid = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (valid_r[j] && (j > int'(p_idx_r))) more_valid = 1'b1;
    end
  end

  // final result and table update per operation
  always_comb begin
    fin_status = ST_NOT_FOUND;
    fin_found  = 1'b0;
    fin_slot   = '0;
    fin_rec    = '0;
    wr_en      = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    wr_idx     = hit_idx_r;
    count_nxt  = count_r;
    unique case (cmd_r.op)
      OP_ADD: begin
        if (hit_r) begin
          fin_status = ST_UPDATED;
          fin_found  = 1'b1;
          fin_slot   = hit_idx_r;
          fin_rec    = cmd_r.rec;
          wr_en      = 1'b1;
        end else if (free_r) begin
          fin_status = ST_ADDED;
          fin_found  = 1'b1;
          fin_slot   = free_idx_r;
          fin_rec    = cmd_r.rec;
          wr_en      = 1'b1;
          set_valid  = 1'b1;
          wr_idx     = free_idx_r;
          count_nxt  = count_r + CNT_W'(1);
        end else begin
          fin_status = ST_FULL;
        end
      end
      OP_DEL: begin
        if (hit_r) begin
          fin_status = ST_DELETED;
          fin_slot   = hit_idx_r;
          clr_valid  = 1'b1;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_LOOK: begin
        if (hit_r) begin
          fin_status = ST_FOUND;
          fin_found  = 1'b1;
          fin_slot   = hit_idx_r;
          fin_rec    = hit_rec_r;
        end
      end
      OP_LIST: fin_status = ST_NOT_FOUND;
      default: fin_status = ST_NOT_FOUND;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_vld) state_nxt = S_SCAN;
      S_SCAN:  if ((idx_r == SCAN_END) && !p_vld_r) state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      count_r    <= '0;
      o_vld_r    <= 1'b0;
      p_vld_r    <= 1'b0;
      idx_r      <= '0;
      p_idx_r    <= '0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      listed_r   <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      o_vld_r <= (o_vld_r && !out_ch.ready) || list_emit || fin_emit;
      if (q_pop) begin
        idx_r    <= '0;
        p_vld_r  <= 1'b0;
        hit_r    <= 1'b0;
        free_r   <= 1'b0;
        listed_r <= 1'b0;
      end
      if (adv) p_vld_r <= issue;
      if (issue) begin
        p_idx_r <= idx_r[IDX_W-1:0];
        idx_r   <= idx_r + SCAN_W'(1);
      end
      if (eval) begin
        if (slot_ok && key_eq && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= p_idx_r;
        end
        if (!slot_ok && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= p_idx_r;
        end
        if (list_emit) listed_r <= 1'b1;
      end
      if (fin_go) begin
        count_r <= count_nxt;
        if (set_valid) valid_r[wr_idx] <= 1'b1;
        if (clr_valid) valid_r[wr_idx] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
    if (eval && slot_ok && key_eq && !hit_r) hit_rec_r <= rd_data_r;
    if (list_emit) begin
      o_status_r <= ST_LIST;
      o_found_r  <= 1'b1;
      o_slot_r   <= SLOT_W'(p_idx_r);
      o_count_r  <= UCNT_W'(count_r);
      o_rec_r    <= rd_data_r;
      o_last_r   <= !more_valid;
    end else if (fin_emit) begin
      o_status_r <= fin_status;
      o_found_r  <= fin_found;
      o_slot_r   <= SLOT_W'(fin_slot);
      o_count_r  <= UCNT_W'(count_nxt);
      o_rec_r    <= fin_rec;
      o_last_r   <= 1'b1;
    end
  end

  // record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (fin_go && wr_en) slot_mem[wr_idx] <= cmd_r.rec;
    if (issue) rd_data_r <= slot_mem[idx_r[IDX_W-1:0]];
  end

  // result channel
  assign out_ch.valid           = o_vld_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.found           = o_found_r;
  assign out_ch.slot            = o_slot_r;
  assign out_ch.user_count      = o_count_r;
  assign out_ch.out_key         = o_rec_r.key;
  assign out_ch.out_name_high   = o_rec_r.name_high;
  assign out_ch.out_name_middle = o_rec_r.name_middle;
  assign out_ch.out_name_low    = o_rec_r.name_low;
  assign out_ch.out_secret      = o_rec_r.secret;
  assign out_ch.last            = o_last_r;

  // checks
  `KRT_ASSERT_IMP(a_count_matches_valid, 1'b1, count_r == CNT_W'($countones(valid_r)))
  `KRT_ASSERT_IMP(a_hit_slot_valid, hit_r && (state_r != S_IDLE), valid_r[hit_idx_r])
  `KRT_ASSERT_IMP(a_free_slot_empty, free_r && (state_r != S_IDLE), !valid_r[free_idx_r])
  `KRT_ASSERT_NXT(a_fin_returns_idle, fin_go, state_r == S_IDLE)

endmodule

`default_nettype wire

[src/keyed_record_table_core.sv]
// Add, delete and lookup results are emitted after the scan of the whole record memory;
//   list entries are emitted as the scan reaches each valid slot.
// The scan reads the record memory one slot per cycle, except while a list entry waits
//   for the sink to take the pending result beat. A two-entry queue takes requests
//   during a scan; the next request starts only once the current one is finished.
// Reset: synchronous, active low; the table comes up empty with a zero count.
`default_nettype none

module keyed_record_table_core #(
  parameter int SLOT_COUNT = krt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  krt_in_if.sink    in_ch,
  krt_out_if.source out_ch
);
  import krt_pkg::*;

  logic q_vld;
  cmd_t q_cmd;
  logic q_pop;

  // accept and classify requests
  krt_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_vld (q_vld),
    .q_cmd (q_cmd),
    .q_pop (q_pop)
  );

  // scan the table and emit results
  krt_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_cmd  (q_cmd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
